/* hw/rtl/chsd_pkg.sv */
`timescale 1ns / 1ps
package chsd_pkg;
    typedef enum logic [2:0] {
        PH_FLAG   = 3'd0,
        PH_HEADER = 3'd1,
        PH_DECODE = 3'd2,
        PH_RAW    = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_BIT,
        ST_TBL_LIM,
        ST_TBL_ORD,
        ST_ORD_WR,
        ST_ENTER,
        ST_LEN,
        ST_LOOK,
        ST_LOOK2,
        ST_EMIT,
        ST_FIN
    } t_state;

    localparam int LONGEST = 15;
    localparam int SPAN    = 16;
endpackage

/* hw/rtl/chsd_out_reg.sv */
`timescale 1ns / 1ps
module chsd_out_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [9:0] i_data,
    output logic       o_full,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [9:0] o_data
);
    logic       r_full;
    logic [9:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_tready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_full   = r_full && !i_tready;
    assign o_tvalid = r_full;
    assign o_data   = r_data;
endmodule

/* hw/rtl/canonical_huffman_stream_decoder_core.sv */
// channel | dir | tdata           | tuser
// s_axis  | in  | [7:0] in_byte   | [0] in_last
// m_axis  | out | [7:0] out_byte  | [0] out_done (tlast = out_last)
// header bytes are shifted one bit per cycle, the flag byte from bit 6 down
// raw and skipped bytes pass from idle straight to the finish state
// decoding searches the limit table one length per cycle, then looks the symbol up in the order table
// after the header the table build walks 16 limits, then reads and places each alphabet entry
// reset clears control; one symbol is held back so tlast can mark the last of a byte
// a stalled output holds the decoder and the input until the beat is taken
`timescale 1ns / 1ps
module canonical_huffman_stream_decoder_core #(
    parameter int ALPHABET_SIZE = 256,
    parameter int WINDOW_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] out_done
);
    localparam int AW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int HBW = $clog2(32 + 4 * ALPHABET_SIZE + 1);

    chsd_pkg::t_state r_st, n_st;
    chsd_pkg::t_phase r_ph, n_ph;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_bcnt, n_bcnt;
    logic        r_last, n_last;
    logic [23:0] r_win, n_win;
    logic [4:0]  r_held, n_held;
    logic [HBW-1:0] r_hbits, n_hbits;
    logic [31:0] r_left, n_left;
    logic [3:0]  r_cur, n_cur;
    logic [8:0]  r_tally [16];
    logic [15:0] r_lim [16];
    logic [8:0]  r_fidx [16];
    logic [8:0]  r_next [16];
    logic [16:0] r_upper, n_upper;
    logic [3:0]  r_b, n_b;
    logic [AW:0] r_i, n_i;
    logic [3:0]  r_len, n_len;
    logic [7:0]  r_sym, n_sym;
    logic        r_done, n_done;
    logic [7:0]  r_psym, n_psym;
    logic        r_pdone, n_pdone;
    logic        r_flush, n_flush;
    logic        r_any, n_any;

    logic [3:0]  len_mem [ALPHABET_SIZE];
    logic [7:0]  ord_mem [256];
    logic [3:0]  len_rd;
    logic [7:0]  ord_rd;
    logic        len_we, ord_we;
    logic [AW-1:0] len_wa, len_ra;
    logic [3:0]  len_wd;
    logic [7:0]  ord_wa, ord_ra, ord_wd;

    logic        tally_inc, lim_we, next_inc, tally_clr;
    logic [3:0]  tally_idx, lim_idx;
    logic [15:0] lim_wd;
    logic [8:0]  fidx_wd;

    logic        out_load, out_full;
    logic [9:0]  out_in, out_q;

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_wa] <= len_wd;
        end
        len_rd <= len_mem[len_ra];
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd <= ord_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || tally_clr) begin
            for (int k = 0; k < 16; k++) begin
                r_tally[k] <= '0;
            end
        end else if (tally_inc) begin
            r_tally[tally_idx] <= r_tally[tally_idx] + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lim_we) begin
            r_lim[lim_idx]  <= lim_wd;
            r_fidx[lim_idx] <= fidx_wd;
            r_next[lim_idx] <= fidx_wd;
        end else if (next_inc) begin
            r_next[len_rd] <= r_next[len_rd] + 9'd1;
        end
    end

    chsd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_in),
        .o_full  (out_full),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_data  (out_q)
    );
    assign m_axis_tdata = out_q[7:0];
    assign m_axis_tlast = out_q[8];
    assign m_axis_tuser = out_q[9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= chsd_pkg::ST_IDLE;
            r_ph    <= chsd_pkg::PH_FLAG;
            r_win   <= '0;
            r_held  <= '0;
            r_hbits <= '0;
            r_left  <= '0;
            r_any   <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_ph    <= n_ph;
            r_win   <= n_win;
            r_held  <= n_held;
            r_hbits <= n_hbits;
            r_left  <= n_left;
            r_any   <= n_any;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_bcnt  <= n_bcnt;
        r_last  <= n_last;
        r_cur   <= n_cur;
        r_upper <= n_upper;
        r_b     <= n_b;
        r_i     <= n_i;
        r_len   <= n_len;
        r_sym   <= n_sym;
        r_done  <= n_done;
        r_psym  <= n_psym;
        r_pdone <= n_pdone;
    end

    logic [15:0] peek, val, base, diff;
    logic [16:0] pos;
    logic [8:0]  total;
    logic [31:0] lim_full;
    logic [4:0]  take;
    logic [23:0] win_mask;
    logic        can_dec;

    always_comb begin
        if (r_held >= 5'd16) begin
            peek = 16'(r_win >> (r_held - 5'd16));
        end else begin
            peek = 16'(r_win << (5'd16 - r_held));
        end
        val   = peek & 16'hfffe;
        base  = r_lim[r_len - 4'd1];
        diff  = (val >= base) ? 16'((val - base) >> (5'd16 - {1'b0, r_len})) : 16'd0;
        pos   = 17'(r_fidx[r_len]) + 17'(diff);
        total = r_fidx[4'd15] + r_tally[4'd15];
        lim_full = 32'(r_upper) << (5'd16 - {1'b0, r_b});
        can_dec = (r_ph == chsd_pkg::PH_DECODE) && (r_left != 32'd0) &&
                  ((r_held >= 5'(WINDOW_BITS)) || (r_flush && r_held != 5'd0));
    end

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_byte = r_byte; n_bcnt = r_bcnt; n_last = r_last;
        n_win = r_win; n_held = r_held; n_hbits = r_hbits; n_left = r_left;
        n_cur = r_cur; n_upper = r_upper; n_b = r_b; n_i = r_i; n_len = r_len;
        n_sym = r_sym; n_done = r_done; n_flush = r_flush; n_any = r_any;
        n_psym = r_psym; n_pdone = r_pdone;
        s_axis_tready = 1'b0;
        len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
        ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
        tally_inc = 1'b0; tally_idx = '0; tally_clr = 1'b0;
        lim_we = 1'b0; lim_idx = '0; lim_wd = '0; fidx_wd = '0; next_inc = 1'b0;
        out_load = 1'b0; out_in = '0;
        take = '0; win_mask = '0;
        unique case (r_st)
            chsd_pkg::ST_IDLE: begin
                s_axis_tready = !out_full;
                if (s_axis_tvalid && !out_full) begin
                    n_byte = s_axis_tdata;
                    n_last = s_axis_tuser;
                    n_any  = 1'b0;
                    n_flush = 1'b0;
                    n_bcnt = 4'd8;
                    n_st   = chsd_pkg::ST_FIN;
                    unique case (r_ph)
                        chsd_pkg::PH_FLAG: begin
                            if (s_axis_tdata[7]) begin
                                tally_clr = 1'b1;
                                n_hbits = '0; n_left = '0; n_win = '0; n_held = '0;
                                n_ph = chsd_pkg::PH_HEADER;
                                n_bcnt = 4'd7;
                                n_byte = {s_axis_tdata[6:0], 1'b0};
                                n_st = chsd_pkg::ST_HDR_BIT;
                            end else begin
                                n_ph = chsd_pkg::PH_RAW;
                            end
                        end
                        chsd_pkg::PH_RAW: begin
                            out_load = 1'b1;
                            out_in = {1'b0, 1'b1, s_axis_tdata};
                        end
                        chsd_pkg::PH_HEADER: n_st = chsd_pkg::ST_HDR_BIT;
                        chsd_pkg::PH_DECODE: begin
                            n_win  = {r_win[15:0], s_axis_tdata};
                            n_held = r_held + 5'd8;
                            n_st   = chsd_pkg::ST_ENTER;
                        end
                        default: ;
                    endcase
                end
            end
            chsd_pkg::ST_HDR_BIT: begin
                if (r_bcnt == 4'd0) begin
                    n_st = chsd_pkg::ST_FIN;
                end else begin
                    n_byte = {r_byte[6:0], 1'b0};
                    n_bcnt = r_bcnt - 4'd1;
                    n_hbits = r_hbits + HBW'(1);
                    if (r_hbits < HBW'(32)) begin
                        n_left = {r_left[30:0], r_byte[7]};
                    end else begin
                        len_wa = AW'((r_hbits - HBW'(32)) >> 2);
                        len_we = 1'b1;
                        len_wd = {r_cur[2:0], r_byte[7]};
                        n_cur  = len_wd;
                        if (r_hbits[1:0] == 2'd0) begin
                            len_wd = {3'd0, r_byte[7]};
                            n_cur = len_wd;
                        end
                        if (r_hbits[1:0] == 2'd3) begin
                            tally_inc = 1'b1;
                            tally_idx = len_wd;
                        end
                    end
                    if (n_hbits == HBW'(32 + 4 * ALPHABET_SIZE)) begin
                        n_b = 4'd0; n_upper = '0;
                        n_st = chsd_pkg::ST_TBL_LIM;
                    end
                end
            end
            chsd_pkg::ST_TBL_LIM: begin
                lim_we = 1'b1;
                lim_idx = r_b;
                if (r_b == 4'd0) begin
                    lim_wd = 16'd0; fidx_wd = 9'd0;
                    n_upper = 17'(r_tally[1]);
                end else begin
                    lim_wd = (lim_full > 32'hffff) ? 16'hffff : lim_full[15:0];
                    fidx_wd = r_fidx[r_b - 4'd1] + ((r_b > 4'd1) ? r_tally[r_b - 4'd1] : 9'd0);
                    n_upper = (r_upper[16] ? 17'h1ffff : {r_upper[15:0], 1'b0}) +
                              17'((r_b == 4'd15) ? 9'd0 : r_tally[r_b + 4'd1]);
                    if (n_upper < r_upper) begin
                        n_upper = 17'h1ffff;
                    end
                end
                n_b = r_b + 4'd1;
                if (r_b == 4'd15) begin
                    n_i = '0;
                    n_st = chsd_pkg::ST_TBL_ORD;
                end
            end
            chsd_pkg::ST_TBL_ORD: begin
                len_ra = r_i[AW-1:0];
                n_st = chsd_pkg::ST_ORD_WR;
            end
            chsd_pkg::ST_ORD_WR: begin
                if (len_rd != 4'd0) begin
                    ord_we = 1'b1;
                    ord_wa = r_next[len_rd][7:0];
                    ord_wd = 8'(r_i);
                    next_inc = 1'b1;
                end
                n_i = r_i + (AW+1)'(1);
                if (r_i == (AW+1)'(ALPHABET_SIZE - 1)) begin
                    n_ph = (r_left != 32'd0) ? chsd_pkg::PH_DECODE : chsd_pkg::PH_DONE;
                    n_win = {16'd0, r_byte};
                    n_held = 5'(r_bcnt);
                    win_mask = (24'd1 << r_bcnt) - 24'd1;
                    n_win = {16'd0, r_byte >> (4'd8 - r_bcnt)} & win_mask;
                    if (r_left == 32'd0) begin
                        n_win = '0; n_held = '0;
                    end
                    n_st = chsd_pkg::ST_ENTER;
                end else begin
                    n_st = chsd_pkg::ST_TBL_ORD;
                end
            end
            chsd_pkg::ST_ENTER: begin
                if (can_dec) begin
                    n_len = 4'd1;
                    n_st = chsd_pkg::ST_LEN;
                end else if (r_last && !r_flush) begin
                    n_flush = 1'b1;
                end else begin
                    n_st = chsd_pkg::ST_FIN;
                end
            end
            chsd_pkg::ST_LEN: begin
                if (val < r_lim[r_len] || r_len == 4'd15) begin
                    if (!r_flush && {1'b0, r_len} > r_held) begin
                        n_st = r_last ? chsd_pkg::ST_ENTER : chsd_pkg::ST_FIN;
                        n_flush = r_last;
                    end else begin
                        n_st = chsd_pkg::ST_LOOK;
                    end
                end else begin
                    n_len = r_len + 4'd1;
                end
            end
            chsd_pkg::ST_LOOK: begin
                ord_ra = pos[7:0];
                n_done = (pos < 17'(total));
                n_st = chsd_pkg::ST_LOOK2;
            end
            chsd_pkg::ST_LOOK2: begin
                n_sym = r_done ? ord_rd : 8'd0;
                take = ({1'b0, r_len} > r_held) ? r_held : {1'b0, r_len};
                n_held = r_held - take;
                win_mask = (24'd1 << n_held) - 24'd1;
                n_win = r_win & win_mask;
                n_left = r_left - 32'd1;
                n_st = chsd_pkg::ST_EMIT;
            end
            chsd_pkg::ST_EMIT: begin
                if (!r_any || !out_full) begin
                    if (r_any) begin
                        out_load = 1'b1;
                        out_in = {r_pdone, 1'b0, r_psym};
                    end
                    n_any = 1'b1;
                    n_psym = r_sym;
                    n_pdone = (r_left == 32'd0);
                    if (r_left == 32'd0) begin
                        n_ph = chsd_pkg::PH_DONE;
                        n_win = '0; n_held = '0;
                    end
                    n_st = chsd_pkg::ST_ENTER;
                end
            end
            chsd_pkg::ST_FIN: begin
                if (!r_any || !out_full) begin
                    if (r_any) begin
                        out_load = 1'b1;
                        out_in = {r_pdone, 1'b1, r_psym};
                        n_any = 1'b0;
                    end
                    if (r_last) begin
                        n_ph = chsd_pkg::PH_FLAG;
                        n_win = '0; n_held = '0; n_hbits = '0; n_left = '0;
                    end
                    n_st = chsd_pkg::ST_IDLE;
                    if (r_ph == chsd_pkg::PH_HEADER && r_bcnt != 4'd0 && !r_last) begin
                        n_st = chsd_pkg::ST_HDR_BIT;
                    end
                end
            end
            default: n_st = chsd_pkg::ST_IDLE;
        endcase
    end
endmodule

/* sim/chsd_checker.sv */
`timescale 1ns / 1ps
module chsd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] in_last
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tlast,
    input  logic       m_axis_tuser,   // [0] out_done
    output int         o_fails,
    output int         o_pending
);
    localparam int ALPHA    = 256;
    localparam int WIN_BITS = 16;
    localparam int MAX_OUT  = 32;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       done;
    } t_sym_beat;

    t_sym_beat        sym_fifo[$];
    chsd_pkg::t_phase ph;
    logic [31:0]      win;
    int               held;
    int               hdr_bits;
    logic [31:0]      left;
    logic [3:0]       lens[ALPHA];
    int               tally[16];
    logic [15:0]      lim[16];
    int               first_idx[16];
    logic [7:0]       order[ALPHA];
    t_sym_beat        step_out[$];

    assign o_pending = sym_fifo.size();

    function automatic void build_tables();
        longint upper;
        longint lv;
        int     nxt[16];
        upper        = 0;
        lim[0]       = '0;
        first_idx[0] = 0;
        for (int b = 1; b <= chsd_pkg::LONGEST; b++) begin
            upper += tally[b];
            lv = upper << (chsd_pkg::SPAN - b);
            lim[b] = (lv > 64'hffff) ? 16'hffff : lv[15:0];
            upper = upper * 2;
            first_idx[b] = first_idx[b-1] + ((b > 1) ? tally[b-1] : 0);
        end
        for (int b = 0; b < 16; b++) nxt[b] = first_idx[b];
        for (int s = 0; s < ALPHA; s++) begin
            if (lens[s] != 0) begin
                order[nxt[lens[s]] & 255] = s[7:0];
                nxt[lens[s]]++;
            end
        end
    endfunction

    function automatic void take_header_bit(input logic bv);
        int off;
        int idx;
        logic [3:0] cur;
        if (hdr_bits < 32) begin
            left = {left[30:0], bv};
        end else begin
            off = hdr_bits - 32;
            idx = (off >> 2) & 255;
            cur = ((off & 3) != 0) ? lens[idx] : 4'd0;
            cur = {cur[2:0], bv};
            lens[idx] = cur;
            if ((off & 3) == 3) tally[cur]++;
        end
        hdr_bits++;
        if (hdr_bits == 32 + 4 * ALPHA) begin
            build_tables();
            ph = (left != 0) ? chsd_pkg::PH_DECODE : chsd_pkg::PH_DONE;
        end
    endfunction

    function automatic logic [15:0] peek_window();
        logic [31:0] v;
        if (held >= chsd_pkg::SPAN) v = win >> (held - chsd_pkg::SPAN);
        else v = win << (chsd_pkg::SPAN - held);
        return v[15:0];
    endfunction

    function automatic int code_len();
        logic [15:0] val;
        val = peek_window() & 16'hfffe;
        for (int i = 1; i < chsd_pkg::LONGEST; i++)
            if (val < lim[i]) return i;
        return chsd_pkg::LONGEST;
    endfunction

    function automatic logic [7:0] lookup_sym(input int len);
        logic [15:0] val;
        int ofs;
        int pos;
        int total;
        val   = peek_window() & 16'hfffe;
        ofs   = (val >= lim[len-1]) ?
                ((int'(val) - int'(lim[len-1])) >> (chsd_pkg::SPAN - len)) : 0;
        pos   = first_idx[len] + ofs;
        total = first_idx[chsd_pkg::LONGEST] + tally[chsd_pkg::LONGEST];
        return (pos < total) ? order[pos & 255] : 8'd0;
    endfunction

    function automatic void push_sym(input logic [7:0] v, input logic dn);
        t_sym_beat e;
        if (step_out.size() >= MAX_OUT) return;
        e.sym  = v;
        e.last = 1'b0;
        e.done = dn;
        step_out.insert(step_out.size(), e);
    endfunction

    function automatic void decode_one(input int len);
        logic [7:0] s;
        int n;
        s = lookup_sym(len);
        n = (len > held) ? held : len;
        held -= n;
        win &= (held != 0) ? ((32'd1 << held) - 1) : 32'd0;
        left--;
        push_sym(s, left == 0);
        if (left == 0) begin
            ph   = chsd_pkg::PH_DONE;
            win  = '0;
            held = 0;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic lst);
        int nb;
        int k;
        int len;
        nb = 8;
        step_out.delete();
        if (ph == chsd_pkg::PH_FLAG) begin
            if (b[7]) begin
                for (int i = 0; i < 16; i++) tally[i] = 0;
                hdr_bits = 0;
                left     = '0;
                win      = '0;
                held     = 0;
                ph       = chsd_pkg::PH_HEADER;
                nb       = 7;
            end else begin
                ph = chsd_pkg::PH_RAW;
                nb = 0;
            end
        end else if (ph == chsd_pkg::PH_RAW) begin
            push_sym(b, 1'b0);
            nb = 0;
        end else if (ph == chsd_pkg::PH_DONE) begin
            nb = 0;
        end

        if (ph == chsd_pkg::PH_HEADER) begin
            for (int i = nb - 1; i >= 0; i--) begin
                if (ph == chsd_pkg::PH_HEADER) begin
                    take_header_bit(b[i]);
                end else begin
                    if (ph == chsd_pkg::PH_DECODE) begin
                        k = i + 1;
                        win = ((win << k) | (b & ((32'd1 << k) - 1))) & 32'hffffff;
                        held += k;
                    end
                    break;
                end
            end
        end else if (ph == chsd_pkg::PH_DECODE && nb == 8) begin
            win = ((win << 8) | b) & 32'hffffff;
            held += 8;
        end

        while (ph == chsd_pkg::PH_DECODE && held >= WIN_BITS && step_out.size() < MAX_OUT) begin
            len = code_len();
            if (len > held) break;
            decode_one(len);
        end
        if (lst) begin
            while (ph == chsd_pkg::PH_DECODE && held > 0 && step_out.size() < MAX_OUT)
                decode_one(code_len());
            ph       = chsd_pkg::PH_FLAG;
            win      = '0;
            held     = 0;
            hdr_bits = 0;
            left     = '0;
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) sym_fifo.insert(sym_fifo.size(), step_out[i]);
    endfunction

    always @(posedge i_clk) begin
        t_sym_beat e;
        if (!i_rst_n) begin
            o_fails  = 0;
            ph       = chsd_pkg::PH_FLAG;
            win      = '0;
            held     = 0;
            hdr_bits = 0;
            left     = '0;
            for (int i = 0; i < 16; i++) tally[i] = 0;
            sym_fifo.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (sym_fifo.size() == 0) begin
                    $error("unexpected beat: out_byte=%0h", m_axis_tdata);
                    o_fails++;
                end else begin
                    e = sym_fifo.pop_front();
                    if (m_axis_tdata !== e.sym) begin
                        $error("out_byte exp=%0h act=%0h", e.sym, m_axis_tdata);
                        o_fails++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("out_last exp=%0b act=%0b", e.last, m_axis_tlast);
                        o_fails++;
                    end
                    if (m_axis_tuser !== e.done) begin
                        $error("out_done exp=%0b act=%0b", e.done, m_axis_tuser);
                        o_fails++;
                    end
                end
            end
        end
    end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tuser;   // [0] in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;   // [0] out_done
    int         fails;
    int         pending;
    int         sent;
    int         hold_reqs;
    logic       stream_bits[$];

    canonical_huffman_stream_decoder_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    chsd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .o_fails      (fails),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[canonical_huffman_stream_decoder_core] ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        int seen;
        seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int g;
        logic hs;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= lst;
        hs = 1'b0;
        while (!hs) begin
            #1;
            hs = s_axis_tready;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        sent++;
    endtask

    task automatic put_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) stream_bits.insert(stream_bits.size(), v[i]);
    endtask

    task automatic send_bits();
        logic [7:0] b;
        int nbytes;
        nbytes = (stream_bits.size() + 7) / 8;
        for (int k = 0; k < nbytes; k++) begin
            for (int j = 7; j >= 0; j--)
                b[j] = (stream_bits.size() > 0) ? stream_bits.pop_front() : 1'b0;
            send_byte(b, k == nbytes - 1);
        end
    endtask

    task automatic send_raw(input int n);
        send_byte({1'b0, 7'($urandom)}, n == 0);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
    endtask

    // mode 0: complete prefix code, 1: random lengths, 2: all zero lengths
    task automatic send_coded(input int mode, input logic [31:0] cnt, input int payload,
                              input logic stall);
        logic [3:0] lens[256];
        int         pool[$];
        int         perm[256];
        int         idx;
        int         tmp;
        int         j;
        for (int i = 0; i < 256; i++) begin
            lens[i] = '0;
            perm[i] = i;
        end
        if (mode == 0) begin
            pool = '{1, 1};
            repeat ($urandom_range(0, 40)) begin
                idx = $urandom_range(0, pool.size() - 1);
                if (pool[idx] < chsd_pkg::LONGEST) begin
                    tmp = pool[idx] + 1;
                    pool[idx] = tmp;
                    pool.insert(pool.size(), tmp);
                end
            end
            for (int i = 255; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            foreach (pool[i]) lens[perm[i]] = 4'(pool[i]);
        end else if (mode == 1) begin
            for (int i = 0; i < 256; i++)
                if ($urandom_range(0, 9) == 0) lens[i] = 4'($urandom);
        end
        stream_bits.delete();
        put_bits(1, 1);
        put_bits(cnt, 32);
        for (int i = 0; i < 256; i++) put_bits(lens[i], 4);
        for (int i = 0; i < payload; i++) put_bits($urandom, 8);
        if (stall) begin
            // fill up: header first, then hold the receiver during the payload
            while (stream_bits.size() > 8 * payload + 8) begin
                send_byte({stream_bits[0], stream_bits[1], stream_bits[2], stream_bits[3],
                           stream_bits[4], stream_bits[5], stream_bits[6],
                           stream_bits[7]}, 1'b0);
                repeat (8) void'(stream_bits.pop_front());
            end
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            hold_reqs++;
            @(negedge i_clk);
        end
        send_bits();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(negedge i_clk);
    endtask

    initial begin
        sent          = 0;
        hold_reqs     = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // raw stream with extreme bytes
        send_byte(8'h7f, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        // single-byte streams, raw and ending in the header
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // header cut short
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
        // count of zero, trailing bytes ignored
        send_coded(2, 32'd0, 1, 1'b0);
        drain();
        // valid code, long receiver hold while the payload is offered
        send_coded(0, $urandom_range(20, 200), 24, 1'b1);
        drain();

        while (sent < 330) begin
            send_raw($urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0) drain();
        end
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (500) @(negedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("[canonical_huffman_stream_decoder_core] OK");
        end else begin
            $display("[canonical_huffman_stream_decoder_core] ERROR");
        end
        $finish;
    end
endmodule
